[hdl/tseq_pkg.sv]
// Package for the typed event queue: default sizes, request codes and the cell control struct.
package tseq_pkg;

  localparam int unsigned DefDepth    = 16;
  localparam int unsigned DefTypeBits = 4;
  localparam int unsigned DefInfoBits = 16;
  localparam int unsigned KindBits    = 2;
  localparam int unsigned PosBits     = 16;

  localparam logic [KindBits-1:0] KindPush     = 2'd0;
  localparam logic [KindBits-1:0] KindPopNew   = 2'd1;
  localparam logic [KindBits-1:0] KindPopIndex = 2'd2;
  localparam logic [KindBits-1:0] KindDrain    = 2'd3;

  typedef struct packed {
    logic shift;
    logic wr_en;
  } cell_ctl_t;

endpackage

[hdl/tseq_cell.sv]
// One storage cell of the event row: loads from the next cell on a shift or takes a write.
module tseq_cell import tseq_pkg::*; #(
  parameter int unsigned INDEX     = 0,
  parameter int unsigned IDX_W     = 4,
  parameter int unsigned TYPE_BITS = DefTypeBits,
  parameter int unsigned INFO_BITS = DefInfoBits
) (
  input  logic                 clk_i,
  input  cell_ctl_t            ctl_i,
  input  logic [IDX_W-1:0]     wr_idx_i,
  input  logic [TYPE_BITS-1:0] wr_type_i,
  input  logic [INFO_BITS-1:0] wr_info_i,
  input  logic [TYPE_BITS-1:0] nb_type_i,
  input  logic [INFO_BITS-1:0] nb_info_i,
  output logic [TYPE_BITS-1:0] type_o,
  output logic [INFO_BITS-1:0] info_o
);

  logic [TYPE_BITS-1:0] type_q;
  logic [INFO_BITS-1:0] info_q;
  logic                 hit;

  assign hit = ctl_i.wr_en && (wr_idx_i == IDX_W'(INDEX));

  always_ff @(posedge clk_i) begin
    if (hit) begin
      type_q <= wr_type_i;
      info_q <= wr_info_i;
    end else if (ctl_i.shift) begin
      type_q <= nb_type_i;
      info_q <= nb_info_i;
    end
  end

  assign type_o = type_q;
  assign info_o = info_q;

endmodule

[hdl/typed_event_queue_selective_pop_unit.sv]
// Typed event queue with push, pop-newest, pop-at-index and drain-by-type over cells.
// Events sit in a row of DEPTH cells, oldest in cell 0. A push writes the tail cell and
// its result leaves from the flush state once the output is free. Pop newest, pop at
// index and drain walk the row: each cycle, unless a match finds an event held while the
// output stalls, the whole row shifts one place toward cell 0; the entry leaving cell 0 is
// returned or rewritten at the tail. A drain holds back one found event so that the final
// one can carry last. The input is ready only while no request is in progress.
module typed_event_queue_selective_pop_unit import tseq_pkg::*; #(
  parameter int unsigned DEPTH     = DefDepth,
  parameter int unsigned TYPE_BITS = DefTypeBits,
  parameter int unsigned INFO_BITS = DefInfoBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [KindBits-1:0]  kind_i,
  input  logic [TYPE_BITS-1:0] event_type_i,
  input  logic [INFO_BITS-1:0] extra_info_i,
  input  logic [PosBits-1:0]   position_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 found_o,
  output logic [TYPE_BITS-1:0] out_type_o,
  output logic [INFO_BITS-1:0] out_info_o,
  output logic                 overflow_o,
  output logic                 last_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StFlush = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic             drain_q, drain_d;
  logic             idx_ok_q, idx_ok_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [TYPE_BITS-1:0] sel_type_q, sel_type_d;
  logic             pend_valid_q, pend_valid_d;
  logic             pend_ovf_q, pend_ovf_d;
  logic [TYPE_BITS-1:0] pend_type_q, pend_type_d;
  logic [INFO_BITS-1:0] pend_info_q, pend_info_d;
  logic             out_valid_q, out_valid_d;
  logic             out_found_q, out_found_d;
  logic             out_ovf_q, out_ovf_d;
  logic             out_last_q, out_last_d;
  logic [TYPE_BITS-1:0] out_type_q, out_type_d;
  logic [INFO_BITS-1:0] out_info_q, out_info_d;

  logic [TYPE_BITS-1:0] cell_type [DEPTH];
  logic [INFO_BITS-1:0] cell_info [DEPTH];
  cell_ctl_t            ctl;
  logic [IDX_W-1:0]     wr_idx;
  logic [TYPE_BITS-1:0] wr_type;
  logic [INFO_BITS-1:0] wr_info;

  logic             accept, out_free, match, step;
  logic [CNT_W-1:0] cnt_m1;
  logic [PosBits-1:0] count_ext;

  assign accept    = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign cnt_m1    = count_q - CNT_W'(1);
  assign count_ext = PosBits'(count_q);
  assign in_ready_o = (state_q == StIdle);

  assign match = drain_q ? ((sel_type_q == '0) || (cell_type[0] == sel_type_q))
                         : (idx_ok_q && (pos_q == idx_q));
  assign step  = (state_q == StScan) && (rem_q != '0) &&
                 !(match && pend_valid_q && !out_free);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int unsigned NB = (i + 1 < DEPTH) ? i + 1 : i;
    tseq_cell #(
      .INDEX     (i),
      .IDX_W     (IDX_W),
      .TYPE_BITS (TYPE_BITS),
      .INFO_BITS (INFO_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .wr_idx_i  (wr_idx),
      .wr_type_i (wr_type),
      .wr_info_i (wr_info),
      .nb_type_i (cell_type[NB]),
      .nb_info_i (cell_info[NB]),
      .type_o    (cell_type[i]),
      .info_o    (cell_info[i])
    );
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rem_d        = rem_q;
    pos_d        = pos_q;
    drain_d      = drain_q;
    idx_ok_d     = idx_ok_q;
    idx_d        = idx_q;
    sel_type_d   = sel_type_q;
    pend_valid_d = pend_valid_q;
    pend_ovf_d   = pend_ovf_q;
    pend_type_d  = pend_type_q;
    pend_info_d  = pend_info_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_found_d  = out_found_q;
    out_ovf_d    = out_ovf_q;
    out_last_d   = out_last_q;
    out_type_d   = out_type_q;
    out_info_d   = out_info_q;
    ctl          = '0;
    wr_idx       = count_q[IDX_W-1:0];
    wr_type      = event_type_i;
    wr_info      = extra_info_i;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          pend_valid_d = 1'b0;
          pend_ovf_d   = 1'b0;
          pend_type_d  = '0;
          pend_info_d  = '0;
          rem_d        = count_q;
          pos_d        = '0;
          sel_type_d   = event_type_i;
          drain_d      = (kind_i == KindDrain);
          idx_ok_d     = 1'b0;
          idx_d        = position_i[IDX_W-1:0];
          state_d      = StScan;
          unique case (kind_i)
            KindPush: begin
              state_d = StFlush;
              if (count_q == CNT_W'(DEPTH)) begin
                pend_ovf_d = 1'b1;
              end else begin
                pend_valid_d = 1'b1;
                ctl.wr_en    = 1'b1;
                count_d      = count_q + CNT_W'(1);
              end
            end
            KindPopNew: begin
              idx_ok_d = (count_q != '0);
              idx_d    = cnt_m1[IDX_W-1:0];
            end
            KindPopIndex: begin
              idx_ok_d = (position_i < count_ext);
            end
            default: ;
          endcase
        end
      end
      StScan: begin
        if (rem_q == '0) begin
          state_d = StFlush;
        end else if (step) begin
          ctl.shift = 1'b1;
          rem_d     = rem_q - CNT_W'(1);
          pos_d     = pos_q + IDX_W'(1);
          if (match) begin
            count_d = cnt_m1;
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_found_d = 1'b1;
              out_ovf_d   = 1'b0;
              out_last_d  = 1'b0;
              out_type_d  = pend_type_q;
              out_info_d  = pend_info_q;
            end
            pend_valid_d = 1'b1;
            pend_type_d  = cell_type[0];
            pend_info_d  = cell_info[0];
          end else begin
            ctl.wr_en = 1'b1;
            wr_idx    = cnt_m1[IDX_W-1:0];
            wr_type   = cell_type[0];
            wr_info   = cell_info[0];
          end
        end
      end
      StFlush: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_found_d  = pend_valid_q;
          out_ovf_d    = pend_ovf_q;
          out_last_d   = 1'b1;
          out_type_d   = pend_valid_q ? pend_type_q : '0;
          out_info_d   = pend_valid_q ? pend_info_q : '0;
          pend_valid_d = 1'b0;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      count_q      <= '0;
      rem_q        <= '0;
      pos_q        <= '0;
      drain_q      <= 1'b0;
      idx_ok_q     <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_ovf_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      rem_q        <= rem_d;
      pos_q        <= pos_d;
      drain_q      <= drain_d;
      idx_ok_q     <= idx_ok_d;
      pend_valid_q <= pend_valid_d;
      pend_ovf_q   <= pend_ovf_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    sel_type_q  <= sel_type_d;
    pend_type_q <= pend_type_d;
    pend_info_q <= pend_info_d;
    out_found_q <= out_found_d;
    out_ovf_q   <= out_ovf_d;
    out_last_q  <= out_last_d;
    out_type_q  <= out_type_d;
    out_info_q  <= out_info_d;
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = out_found_q;
  assign out_type_o  = out_type_q;
  assign out_info_o  = out_info_q;
  assign overflow_o  = out_ovf_q;
  assign last_o      = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (rem_q <= count_q))
    else $error("scan remainder above fill count");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !pend_valid_q)
    else $error("held event left over in idle");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_i == KindPush) && (count_q != CNT_W'(DEPTH)))
      |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("accepted push did not grow the queue");

endmodule
